// ===== src/brf_pkg.sv =====
// Shared types and constants for the bulk ring FIFO.
`timescale 1ns / 1ps
package brf_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;
  localparam int QUEUE_DEPTH   = 4;

  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;
  localparam int LOG2_W = 4;

  localparam logic [LOG2_W-1:0] LOG2_RST = 4'd10;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } brf_cmd_t;

  // Status from the back part towards the front part and the top level.
  typedef struct packed {
    logic streaming;  // a read stream is being issued from the ring
    logic rd_done;    // the final ring read of a stream is issued this cycle
  } brf_bk_stat_t;

endpackage

// ===== src/bulk_ring_fifo_top.sv =====
// Top level of the bulk ring FIFO with all-or-nothing burst transfers.
`timescale 1ns / 1ps
// Ring FIFO of 32-bit words with all-or-nothing bulk writes and counted reads.
// Input stream: in_tuser carries cmd (0 write word, 1 read request) and first;
// in_tdata carries length and the word to store. A write burst gives its
// length on its first word; if the free space is short, every word of the
// burst is refused. Each write transaction gives one status result; a read
// gives one error result, one ok result for a count of zero, or the words in
// order with the final one marked by out_tlast.
// A write or single result passes through the command queue and then the result
// register. A read stream issues its words from the ring one at a time: each
// word goes through a registered ring read before the result register, and the
// next read is issued as the previous word is taken. Write results sustain one
// per cycle while the receiver keeps out_tready high and no stream is issued.
// Write transactions are held off (in_tready low) while an accepted read
// stream has not yet fetched all its words from the ring.
// Reset (rst_n low, synchronous) empties the ring and sets ring_log2 to 10;
// the ring memory itself is not cleared. A cfg_wen write sets ring_log2 and
// empties the ring. When the receiver stalls, the result register holds and
// the four-entry command queue fills before in_tready falls.
module bulk_ring_fifo_top
  import brf_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wen,
  input  logic [LOG2_W-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // length[6:0], data[38:7], zero[39]
  input  logic [1:0]        in_tuser,   // cmd[0], first[1]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // data_res[31:0]
  output logic [1:0]        out_tuser,  // status[0], has_data[1]
  output logic              out_tlast
);

  localparam int CL     = $clog2(DEPTH);
  localparam int MAX_LG = ((1 << CL) > DEPTH) ? CL - 1 : CL;
  localparam int IDX_W  = MAX_LG;
  localparam int QW     = IDX_W + LEN_W + 2;

  logic              q_push, q_ready, q_pop, q_valid;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, ring_mask;
  logic [DATA_W-1:0] wr_data;
  brf_bk_stat_t      bk_stat;

  brf_front #(
    .IDX_W     (IDX_W),
    .MAX_LG    (MAX_LG),
    .MAX_BURST (MAX_BURST),
    .QW        (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser[0]),
    .in_first  (in_tuser[1]),
    .in_length (in_tdata[6:0]),
    .in_data   (in_tdata[38:7]),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_ready   (q_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .ring_mask (ring_mask),
    .bk_stat   (bk_stat)
  );

  brf_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata)
  );

  brf_back #(
    .IDX_W (IDX_W),
    .QW    (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ring_mask  (ring_mask),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .bk_stat    (bk_stat)
  );

`ifndef SYNTH
  // The ring is never written while a read stream is still fetching words.
  a_no_write_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !bk_stat.streaming)
    else $error("ring written during a read stream");

  // The front part never pushes into a full command queue.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("command queue overflow");

  // The final ring read of a stream shows up as a marked data result via rd_data_r.
  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.rd_done |-> ##2 (out_tvalid && out_tlast && out_tuser[1]))
    else $error("stream end not delivered as last data word");
`endif

endmodule

// ===== src/brf_queue.sv =====
// Small register queue that decouples the front and back parts.
`timescale 1ns / 1ps
module brf_queue
  import brf_pkg::*;
#(
  parameter int WIDTH = 19,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/brf_front.sv =====
// Front part: accepts transactions, keeps the ring indices and decides each outcome.
`timescale 1ns / 1ps
module brf_front
  import brf_pkg::*;
#(
  parameter int IDX_W     = 10,
  parameter int MAX_LG    = 10,
  parameter int MAX_BURST = MAX_BURST_DEF,
  parameter int QW        = IDX_W + 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [LOG2_W-1:0]   cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_cmd,
  input  logic                in_first,
  input  logic [LEN_W-1:0]    in_length,
  input  logic [DATA_W-1:0]   in_data,
  output logic                q_push,
  output logic [QW-1:0]       q_data,
  input  logic                q_ready,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [DATA_W-1:0]   wr_data,
  output logic [IDX_W-1:0]    ring_mask,
  input  brf_bk_stat_t        bk_stat
);

  localparam int CW    = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam int OUT_W = $clog2(QUEUE_DEPTH + 2);

  logic [LOG2_W-1:0] ring_log2_r;
  logic [IDX_W-1:0]  prod_r, prod_nxt;
  logic [IDX_W-1:0]  cons_r, cons_nxt;
  logic [IDX_W-1:0]  bpos_r, bpos_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              bok_r, bok_nxt;
  logic [OUT_W-1:0]  rd_out_r, rd_out_nxt;
  logic [LOG2_W:0]   lg;
  logic [IDX_W-1:0]  free_sp, fill;
  logic              accept, bad_len, q_single, q_status, stream;
  logic [IDX_W-1:0]  q_addr;
  brf_cmd_t          cmd;

  assign cmd = brf_cmd_t'(in_cmd);

  // Ring size clamped to the built depth, and never below two cells.
  always_comb begin
    lg = {1'b0, ring_log2_r};
    if (lg == '0) begin
      lg = (LOG2_W + 1)'(1);
    end else if (lg > (LOG2_W + 1)'(MAX_LG)) begin
      lg = (LOG2_W + 1)'(MAX_LG);
    end
  end

  assign ring_mask = ~({IDX_W{1'b1}} << lg);
  assign free_sp   = (cons_r - prod_r - 1'b1) & ring_mask;
  assign fill      = (prod_r - cons_r) & ring_mask;
  assign bad_len   = (in_length == '0) || (in_length > LEN_W'(MAX_BURST));

  // Writes wait until every queued read stream has fetched its words.
  assign in_tready = q_ready && ((cmd == CMD_READ) || (rd_out_r == '0));
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    prod_nxt = prod_r;
    cons_nxt = cons_r;
    bpos_nxt = bpos_r;
    left_nxt = left_r;
    bok_nxt  = bok_r;
    wr_en    = 1'b0;
    wr_addr  = bpos_r & ring_mask;
    wr_data  = in_data;
    q_single = 1'b1;
    q_status = ST_ERR;
    q_addr   = cons_r & ring_mask;
    stream   = 1'b0;
    if (cmd == CMD_WRITE) begin
      if (in_first) begin
        bpos_nxt = prod_r;
        if (bad_len) begin
          left_nxt = '0;
          bok_nxt  = 1'b0;
        end else begin
          left_nxt = in_length;
          bok_nxt  = (CW'(free_sp) >= CW'(in_length));
        end
      end
      if (left_nxt != '0) begin
        left_nxt = left_nxt - 1'b1;
        if (bok_nxt) begin
          wr_en    = 1'b1;
          wr_addr  = bpos_nxt & ring_mask;
          bpos_nxt = bpos_nxt + 1'b1;
          if (left_nxt == '0) begin
            prod_nxt = bpos_nxt;
          end
          q_status = ST_OK;
        end
      end
    end else begin
      if (bad_len && (in_length == '0)) begin
        q_status = ST_OK;
      end else if (!bad_len && (CW'(fill) >= CW'(in_length))) begin
        q_single = 1'b0;
        q_status = ST_OK;
        stream   = 1'b1;
        cons_nxt = cons_r + IDX_W'(in_length);
      end
    end
    if (!accept) begin
      wr_en    = 1'b0;
      stream   = 1'b0;
      prod_nxt = prod_r;
      cons_nxt = cons_r;
      bpos_nxt = bpos_r;
      left_nxt = left_r;
      bok_nxt  = bok_r;
    end
    rd_out_nxt = rd_out_r;
    if (stream && !bk_stat.rd_done) begin
      rd_out_nxt = rd_out_r + 1'b1;
    end else if (!stream && bk_stat.rd_done) begin
      rd_out_nxt = rd_out_r - 1'b1;
    end
  end

  assign q_push = accept;
  assign q_data = {q_single, q_status, q_addr, in_length};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_log2_r <= LOG2_RST;
      prod_r      <= '0;
      cons_r      <= '0;
      bpos_r      <= '0;
      left_r      <= '0;
      bok_r       <= 1'b0;
      rd_out_r    <= '0;
    end else if (cfg_wen) begin
      // A new ring size empties the ring and drops any open burst.
      ring_log2_r <= cfg_wdata;
      prod_r      <= '0;
      cons_r      <= '0;
      bpos_r      <= '0;
      left_r      <= '0;
      bok_r       <= 1'b0;
      rd_out_r    <= rd_out_nxt;
    end else begin
      prod_r   <= prod_nxt;
      cons_r   <= cons_nxt;
      bpos_r   <= bpos_nxt;
      left_r   <= left_nxt;
      bok_r    <= bok_nxt;
      rd_out_r <= rd_out_nxt;
    end
  end

endmodule

// ===== src/brf_back.sv =====
// Back part: holds the ring memory, streams read bursts and drives the result register.
`timescale 1ns / 1ps
module brf_back
  import brf_pkg::*;
#(
  parameter int IDX_W = 10,
  parameter int QW    = IDX_W + 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    ring_mask,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [DATA_W-1:0]   wr_data,
  input  logic                q_valid,
  input  logic [QW-1:0]       q_data,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast,
  output brf_bk_stat_t        bk_stat
);

  localparam int MEM_D = 1 << IDX_W;

  logic [DATA_W-1:0] mem [MEM_D];
  logic [DATA_W-1:0] rd_data_r;
  logic              busy_r, pend_r, pend_last_r;
  logic [IDX_W-1:0]  addr_r;
  logic [LEN_W-1:0]  left_r;
  logic              out_free, issue;
  logic              e_single, e_status;
  logic [IDX_W-1:0]  e_addr;
  logic [LEN_W-1:0]  e_count;
  logic              ov_r, olast_r;
  logic [1:0]        ouser_r;
  logic [DATA_W-1:0] odata_r;

  assign {e_single, e_status, e_addr, e_count} = q_data;

  // A ring read is issued only when the result register will be free as its word lands.
  assign out_free = !ov_r || out_tready;
  assign issue    = busy_r && !pend_r && out_free;
  assign q_pop    = !busy_r && !pend_r && q_valid && out_free;

  assign bk_stat.streaming = busy_r;
  assign bk_stat.rd_done   = issue && (left_r == LEN_W'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if (q_pop && !e_single) begin
        busy_r <= 1'b1;
      end else if (bk_stat.rd_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_r <= e_addr;
      left_r <= e_count;
    end else if (issue) begin
      addr_r <= (addr_r + 1'b1) & ring_mask;
      left_r <= left_r - 1'b1;
    end
    if (issue) begin
      pend_last_r <= (left_r == LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (pend_r || (q_pop && e_single)) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      odata_r <= rd_data_r;
      ouser_r <= {1'b1, ST_OK};
      olast_r <= pend_last_r;
    end else if (q_pop && e_single) begin
      odata_r <= '0;
      ouser_r <= {1'b0, e_status};
      olast_r <= 1'b1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule

// ===== dv/tb_bulk_ring_fifo_top.sv =====
// Self-checking testbench for the bulk ring FIFO top level.
`timescale 1ns / 1ps
module tb_bulk_ring_fifo_top;
  import brf_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic        status;
    logic        has_data;
    logic [31:0] data;
    logic        last;
  } ring_result_t;

  // Shadow copy of the ring: predicts the results of every accepted input transaction
  // and compares them with what the block returns.
  class ring_shadow;
    logic [31:0]       cells [DEPTH_DEF];
    bit [31:0]         produce_idx;
    bit [31:0]         consume_idx;
    bit [31:0]         burst_pos;
    bit [LEN_W-1:0]    burst_left;
    bit                burst_ok;
    bit [LOG2_W-1:0]   ring_log2;
    ring_result_t      due_results [$];
    int                fails;

    function new();
      ring_log2 = LOG2_RST;
      fails     = 0;
      set_ring(LOG2_RST);
    endfunction

    function void set_ring(bit [LOG2_W-1:0] lg);
      ring_log2   = lg;
      produce_idx = '0;
      consume_idx = '0;
      burst_pos   = '0;
      burst_left  = '0;
      burst_ok    = 1'b0;
    endfunction

    // Out-of-range sizes are clamped to the smallest ring and the built depth.
    function int unsigned ring_mask();
      int unsigned lg;
      lg = ring_log2;
      if (lg < 1) lg = 1;
      while (lg > 1 && (1 << lg) > DEPTH_DEF) lg--;
      return (1 << lg) - 1;
    endfunction

    function int unsigned stored();
      return (produce_idx - consume_idx) & ring_mask();
    endfunction

    // One cell always stays empty, so the free space is one less than the gap.
    function int unsigned free_space();
      return (consume_idx - produce_idx - 1) & ring_mask();
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void take_input(brf_cmd_t cmd, bit first, bit [LEN_W-1:0] len, bit [31:0] word);
      ring_result_t r;
      int unsigned  m;
      m = ring_mask();
      r = '{status: ST_ERR, has_data: 1'b0, data: '0, last: 1'b1};
      if (cmd == CMD_WRITE) begin
        if (first) begin
          // A new first word abandons any open burst without publishing it.
          burst_pos = produce_idx;
          if (len == 0 || len > MAX_BURST_DEF) begin
            burst_left = '0;
            burst_ok   = 1'b0;
          end else begin
            burst_left = len;
            burst_ok   = (free_space() >= len);
          end
        end
        if (burst_left != 0) begin
          burst_left--;
          if (burst_ok) begin
            cells[burst_pos & m] = word;
            burst_pos++;
            if (burst_left == 0) produce_idx = burst_pos;
            r.status = ST_OK;
          end
        end
        due_results.push_back(r);
      end else if (len > MAX_BURST_DEF || stored() < len) begin
        due_results.push_back(r);
      end else if (len == 0) begin
        r.status = ST_OK;
        due_results.push_back(r);
      end else begin
        for (int i = 0; i < len; i++) begin
          r.status   = ST_OK;
          r.has_data = 1'b1;
          r.data     = cells[(consume_idx + i) & m];
          r.last     = (i == len - 1);
          due_results.push_back(r);
        end
        consume_idx += len;
      end
    endfunction

    function void check_output(logic st, logic hd, logic [31:0] word, logic lst);
      ring_result_t e;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result with none due: status %b has_data %b data %h last %b",
                   $realtime, st, hd, word, lst);
        return;
      end
      e = due_results.pop_front();
      if (st !== e.status || hd !== e.has_data || word !== e.data || lst !== e.last) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result mismatch: expected status %b has_data %b data %h last %b,",
                   $realtime, e.status, e.has_data, e.data, e.last,
                   " got status %b has_data %b data %h last %b", st, hd, word, lst);
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_wen    = 1'b0;
  logic [LOG2_W-1:0] cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata   = '0;  // length[6:0], data[38:7], zero[39]
  logic [1:0]        in_tuser   = '0;  // cmd[0], first[1]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;        // data_res[31:0]
  logic [1:0]        out_tuser;        // status[0], has_data[1]
  logic              out_tlast;

  ring_shadow        shadow = new();
  bit                calm = 1'b0;
  int                stall_left = 0;
  int                items_sent = 0;
  int                cycles = 0;
  bit [LOG2_W-1:0]   ring_sizes [8] = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd2, 4'd10, 4'd6, 4'd4};

  bulk_ring_fifo_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all in calm phases.
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 11) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 2);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      shadow.check_output(out_tuser[0], out_tuser[1], out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called just after a rising edge; returns just after the edge that accepts the transaction.
  task automatic send(brf_cmd_t cmd, bit first, bit [LEN_W-1:0] len, bit [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {first, cmd};
    in_tdata  <= {1'b0, word, len};
    do @(posedge clk); while (!in_tready);
    shadow.take_input(cmd, first, len, word);
    items_sent++;
  endtask

  // Holds the sender back until every predicted result has been taken.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned fill, freesp, len, n_words, start, kind;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset ring size.
    send(CMD_READ, 1'b0, 7'd0, 32'h0);
    send(CMD_READ, 1'b1, 7'd1, 32'hFFFF_FFFF);
    send(CMD_WRITE, 1'b1, 7'd1, 32'hFFFF_FFFF);
    send(CMD_WRITE, 1'b1, 7'd3, 32'h0000_0000);
    send(CMD_WRITE, 1'b0, 7'd127, 32'hA5A5_A5A5);
    send(CMD_WRITE, 1'b0, 7'd0, 32'h5A5A_5A5A);
    send(CMD_READ, 1'b0, 7'd4, $urandom);
    send(CMD_WRITE, 1'b1, 7'd0, $urandom);
    send(CMD_WRITE, 1'b1, 7'd127, $urandom);
    send(CMD_WRITE, 1'b1, 7'd65, $urandom);
    send(CMD_WRITE, 1'b0, 7'd5, $urandom);
    // A burst cut short by a new first word is never published.
    send(CMD_WRITE, 1'b1, 7'd2, 32'h1111_1111);
    send(CMD_WRITE, 1'b1, 7'd1, 32'h2222_2222);
    send(CMD_WRITE, 1'b1, 7'd64, 32'h3333_3333);
    send(CMD_READ, 1'b0, 7'd1, $urandom);
    send(CMD_WRITE, 1'b1, 7'd2, 32'h4444_4444);
    send(CMD_WRITE, 1'b0, 7'd2, 32'h5555_5555);
    send(CMD_READ, 1'b0, 7'd127, $urandom);
    send(CMD_READ, 1'b1, 7'd64, $urandom);
    send(CMD_READ, 1'b0, 7'd2, $urandom);

    foreach (ring_sizes[p]) begin
      // Leave a burst open so that the size change has one to drop.
      send(CMD_WRITE, 1'b1, 7'($urandom_range(2, 8)), $urandom);
      settle();
      cfg_wen   <= 1'b1;
      cfg_wdata <= ring_sizes[p];
      @(posedge clk);
      cfg_wen <= 1'b0;
      shadow.set_ring(ring_sizes[p]);
      calm = (p % 3 == 1);
      send(CMD_WRITE, 1'b0, 7'($urandom_range(0, 127)), $urandom);
      start = items_sent;
      while (items_sent - start < 5) begin
        kind = $urandom_range(0, 19);
        if (kind < 9) begin
          freesp = shadow.free_space();
          if ($urandom_range(0, 47) == 0) len = 64;
          else if (freesp >= 1 && freesp <= 64 && $urandom_range(0, 5) == 0) len = freesp;
          else len = $urandom_range(1, 8);
          n_words = len;
          if ($urandom_range(0, 9) == 0) n_words = $urandom_range(1, len);
          for (int i = 0; i < n_words; i++)
            send(CMD_WRITE, i == 0, (i == 0) ? 7'(len) : 7'($urandom_range(0, 127)),
                 $urandom);
        end else if (kind < 17) begin
          fill = shadow.stored();
          kind = $urandom_range(0, 9);
          if (kind < 6 && fill > 0) len = $urandom_range(1, (fill > 64) ? 64 : fill);
          else if (kind < 7) len = 0;
          else if (kind < 9) len = (fill < 64) ? $urandom_range(fill + 1, 64) : 64;
          else len = $urandom_range(65, 127);
          send(CMD_READ, 1'($urandom_range(0, 1)), 7'(len), $urandom);
        end else if (kind == 17) begin
          send(CMD_WRITE, 1'b0, 7'($urandom_range(0, 127)), $urandom);
        end else begin
          len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
          send(CMD_WRITE, 1'b1, 7'(len), $urandom);
        end
      end
    end

    settle();
    if (shadow.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== bulk_ring_fifo_top.f =====
src/brf_pkg.sv
src/brf_queue.sv
src/brf_front.sv
src/brf_back.sv
src/bulk_ring_fifo_top.sv
dv/tb_bulk_ring_fifo_top.sv
